// File: sv/gpsr_pkg.sv
// ----------------------------------------------------------------------------
// gpsr_pkg
// Shared widths, register indexes and reset values of the steering regulator.
// ----------------------------------------------------------------------------
package gpsr_pkg;

    localparam int ANGLE_W = 16;            // Q8.8 angle
    localparam int ERR_W   = ANGLE_W + 1;   // setpoint - actual
    localparam int DIFF_W  = ERR_W + 1;     // error - last error
    localparam int GAIN_W  = 32;            // Q8.24 gain
    localparam int FIX_W   = 32;            // Q16.16 drive / integral
    localparam int LIM_W   = 31;            // unsigned integral clamp
    localparam int FRAC_SH = 16;            // Q8.8 x Q8.24 -> Q16.16
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_GAIN_PROP      = 3'd0;
    localparam cfg_index_t REG_GAIN_INT_DT    = 3'd1;
    localparam cfg_index_t REG_GAIN_DERIV_DT  = 3'd2;
    localparam cfg_index_t REG_INTEGRAL_LIMIT = 3'd3;
    localparam cfg_index_t REG_DRIVE_MIN      = 3'd4;
    localparam cfg_index_t REG_DRIVE_MAX      = 3'd5;

    localparam logic signed [GAIN_W-1:0] RST_GAIN_PROP      = 32'sd13421773;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_INT_DT    = 32'sd1678;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_DERIV_DT  = 32'sd0;
    localparam logic        [LIM_W-1:0]  RST_INTEGRAL_LIMIT = 31'd655360;
    localparam logic signed [FIX_W-1:0]  RST_DRIVE_MIN      = -32'sd65536;
    localparam logic signed [FIX_W-1:0]  RST_DRIVE_MAX      = 32'sd65536;

endpackage

// File: sv/gated_pid_steering_regulator.sv
// ----------------------------------------------------------------------------
// gated_pid_steering_regulator
// PID steering loop with integral clamp, sum-overflow guard and safety gate.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid/in_ready): safe, setpoint, actual (Q8.8 angles).
//   Output beat (out_valid/out_ready): drive, integral_now, error_now,
//   overflow; exactly one output beat per input beat, in order.
//   Config: cfg_we/cfg_index/cfg_data write one gain or bound register per
//   cycle; indexes past the last register are ignored. Write only when idle.
// Timing:
//   Three register stages: input register, product register (error and the
//   three gain multiplies), result register (integral accumulate, clamp, sum,
//   saturation); out_valid is the result register's valid. One beat per
//   cycle while out_ready is high; the integral recurrence closes inside the
//   last stage, the derivative history inside the product stage.
// Reset:
//   All stages empty, gains and bounds at their defaults, integral, last
//   error and the derivative-enable flag cleared.
// Stall:
//   Each stage holds while the next is full and not moving; in_ready drops
//   only once all three stages hold beats.
// ----------------------------------------------------------------------------
module gated_pid_steering_regulator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  gpsr_pkg::cfg_index_t                   cfg_index,
    input  logic [gpsr_pkg::FIX_W-1:0]             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   safe,
    input  logic signed [gpsr_pkg::ANGLE_W-1:0]    setpoint,
    input  logic signed [gpsr_pkg::ANGLE_W-1:0]    actual,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [gpsr_pkg::FIX_W-1:0]      drive,
    output logic signed [gpsr_pkg::FIX_W-1:0]      integral_now,
    output logic signed [gpsr_pkg::ERR_W-1:0]      error_now,
    output logic                                   overflow
);
    import gpsr_pkg::*;

    localparam int PT_W  = ERR_W + GAIN_W - FRAC_SH;   // P and I increment
    localparam int DT_W  = DIFF_W + GAIN_W - FRAC_SH;  // D term
    localparam int ACC_W = PT_W + 1;
    localparam int SUM_W = DT_W + 2;

    // configuration registers
    logic signed [GAIN_W-1:0] gain_prop_reg, gain_int_dt_reg, gain_deriv_dt_reg;
    logic        [LIM_W-1:0]  integral_limit_reg;
    logic signed [FIX_W-1:0]  drive_min_reg, drive_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg      <= RST_GAIN_PROP;
            gain_int_dt_reg    <= RST_GAIN_INT_DT;
            gain_deriv_dt_reg  <= RST_GAIN_DERIV_DT;
            integral_limit_reg <= RST_INTEGRAL_LIMIT;
            drive_min_reg      <= RST_DRIVE_MIN;
            drive_max_reg      <= RST_DRIVE_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_PROP:      gain_prop_reg      <= cfg_data;
                REG_GAIN_INT_DT:    gain_int_dt_reg    <= cfg_data;
                REG_GAIN_DERIV_DT:  gain_deriv_dt_reg  <= cfg_data;
                REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[LIM_W-1:0];
                REG_DRIVE_MIN:      drive_min_reg      <= cfg_data;
                REG_DRIVE_MAX:      drive_max_reg      <= cfg_data;
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage control
    // ------------------------------------------------------------------
    logic s0_valid_reg, s1_valid_reg, out_valid_reg;
    logic out_adv, s1_ready, s0_move, s1_move, in_take;

    assign out_adv  = !out_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || out_adv;
    assign s1_move  = s1_valid_reg && out_adv;
    assign s0_move  = s0_valid_reg && s1_ready;
    assign in_ready = !s0_valid_reg || s1_ready;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s0_valid_reg <= in_valid;
            if (s1_ready)
                s1_valid_reg <= s0_valid_reg;
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 0: input register
    // ------------------------------------------------------------------
    logic                      s0_safe_reg;
    logic signed [ANGLE_W-1:0] s0_setpoint_reg, s0_actual_reg;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s0_safe_reg     <= safe;
            s0_setpoint_reg <= setpoint;
            s0_actual_reg   <= actual;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: error, derivative history, gain products
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PT_W-1:0]   p_term, i_inc;
    logic signed [DT_W-1:0]   d_term;

    logic signed [ERR_W-1:0]  last_err_reg, last_err_next;
    logic                     primed_reg, primed_next;

    assign err  = ERR_W'(s0_setpoint_reg) - ERR_W'(s0_actual_reg);
    // no derivative on the first safe beat after reset or an unsafe beat
    assign diff = primed_reg ? (DIFF_W'(err) - DIFF_W'(last_err_reg)) : '0;

    gpsr_mulq #(.VW(ERR_W)) u_mul_p (
        .v    (err),
        .gain (gain_prop_reg),
        .q    (p_term)
    );

    gpsr_mulq #(.VW(ERR_W)) u_mul_i (
        .v    (err),
        .gain (gain_int_dt_reg),
        .q    (i_inc)
    );

    gpsr_mulq #(.VW(DIFF_W)) u_mul_d (
        .v    (diff),
        .gain (gain_deriv_dt_reg),
        .q    (d_term)
    );

    always_comb
    begin
        last_err_next = last_err_reg;
        primed_next   = primed_reg;
        if (s0_move)
        begin
            last_err_next = s0_safe_reg ? err : '0;
            primed_next   = s0_safe_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg <= '0;
            primed_reg   <= 1'b0;
        end
        else
        begin
            last_err_reg <= last_err_next;
            primed_reg   <= primed_next;
        end
    end

    logic                    s1_safe_reg;
    logic signed [ERR_W-1:0] s1_err_reg;
    logic signed [PT_W-1:0]  s1_p_reg, s1_i_reg;
    logic signed [DT_W-1:0]  s1_d_reg;

    always_ff @(posedge clk)
    begin
        if (s0_move)
        begin
            s1_safe_reg <= s0_safe_reg;
            s1_err_reg  <= err;
            s1_p_reg    <= p_term;
            s1_i_reg    <= i_inc;
            s1_d_reg    <= d_term;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: integral, sum, overflow guard, saturation
    // ------------------------------------------------------------------
    logic signed [FIX_W-1:0] integral_reg, integral_next;
    logic signed [ACC_W-1:0] acc_raw, lim_pos, lim_neg, acc_clamped;
    logic signed [FIX_W-1:0] acc32;
    logic signed [SUM_W-1:0] sum;
    logic                    ovf;
    logic signed [FIX_W-1:0] pre_sat, sat_lo, drive_next;

    always_comb
    begin
        lim_pos = ACC_W'(integral_limit_reg);
        lim_neg = -lim_pos;
        acc_raw = ACC_W'(integral_reg) + ACC_W'(s1_i_reg);
        priority if (acc_raw > lim_pos)
            acc_clamped = lim_pos;
        else if (acc_raw < lim_neg)
            acc_clamped = lim_neg;
        else
            acc_clamped = acc_raw;
        acc32 = acc_clamped[FIX_W-1:0];

        sum = SUM_W'(s1_p_reg) + SUM_W'(acc32) + SUM_W'(s1_d_reg);
        // outside the signed 32-bit range when the upper bits disagree
        ovf = (sum[SUM_W-1:FIX_W-1] != '0) && (sum[SUM_W-1:FIX_W-1] != '1);

        pre_sat = ovf ? '0 : sum[FIX_W-1:0];
        sat_lo  = (pre_sat < drive_min_reg) ? drive_min_reg : pre_sat;
        // max bound applied last, so it wins on inverted bounds
        drive_next = (sat_lo > drive_max_reg) ? drive_max_reg : sat_lo;

        integral_next = integral_reg;
        if (s1_move)
            integral_next = (s1_safe_reg && !ovf) ? acc32 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            integral_reg <= '0;
        else
            integral_reg <= integral_next;
    end

    logic signed [FIX_W-1:0] drive_reg, integral_now_reg;
    logic signed [ERR_W-1:0] error_now_reg;
    logic                    overflow_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            drive_reg        <= s1_safe_reg ? drive_next : '0;
            integral_now_reg <= integral_next;
            error_now_reg    <= s1_err_reg;
            overflow_reg     <= s1_safe_reg && ovf;
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive        = drive_reg;
    assign integral_now = integral_now_reg;
    assign error_now    = error_now_reg;
    assign overflow     = overflow_reg;

endmodule

// File: sv/gpsr_mulq.sv
// ----------------------------------------------------------------------------
// gpsr_mulq
// Signed Q8.8 value times signed Q8.24 gain, rounded half up to Q16.16.
// ----------------------------------------------------------------------------
module gpsr_mulq #(
    parameter int VW = 17
) (
    input  logic signed [VW-1:0]              v,
    input  logic signed [gpsr_pkg::GAIN_W-1:0] gain,
    output logic signed [VW+gpsr_pkg::GAIN_W-gpsr_pkg::FRAC_SH-1:0] q
);
    import gpsr_pkg::*;

    localparam int PW = VW + GAIN_W;

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] rnd;

    assign prod = PW'(v) * PW'(gain);
    assign rnd  = prod + PW'(1 << (FRAC_SH - 1));
    // arithmetic shift, keep the upper bits
    assign q    = rnd[PW-1:FRAC_SH];

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gated PID steering regulator. A short table of
// directed ticks and register writes is walked first: reset values, angle
// extremes, the safety gate, the derivative priming, sum overflow, a zero
// integral clamp, inverted drive bounds and writes to unused indexes. Random
// phases follow, each with its own register setting and handshake pacing.
// Every result beat is compared field by field against an in-bench model of
// the control law, or against a fixed expectation for typed rows.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import gpsr_pkg::*;

    localparam cfg_index_t REG_UNUSED_LO = 3'd6;
    localparam cfg_index_t REG_UNUSED_HI = 3'd7;

    localparam int  NUM_PHASES      = 10;
    localparam int  TICKS_PER_PHASE = 90;
    localparam int  HOLD_CYCLES     = 80;
    localparam int  SETTLE_CYCLES   = 8;
    localparam int  CYCLE_LIMIT     = 200000;
    localparam int  MAX_PRINTED     = 40;
    localparam longint S32_MAX      = 64'sd2147483647;
    localparam longint S32_MIN      = -64'sd2147483648;

    typedef struct packed {
        logic signed [FIX_W-1:0] drive;
        logic signed [FIX_W-1:0] integ;
        logic signed [ERR_W-1:0] err;
        logic                    ovf;
    } steer_result_t;

    typedef enum logic [1:0] {ROW_TICK, ROW_TICK_TYPED, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic                      safe;
        logic signed [ANGLE_W-1:0] sp;
        logic signed [ANGLE_W-1:0] act;
        cfg_index_t                idx;
        logic [FIX_W-1:0]          data;
        steer_result_t             want;
    } plan_row_t;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    cfg_index_t                cfg_index = REG_GAIN_PROP;
    logic [FIX_W-1:0]          cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic                      safe      = 1'b0;
    logic signed [ANGLE_W-1:0] setpoint  = '0;
    logic signed [ANGLE_W-1:0] actual    = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [FIX_W-1:0]   drive;
    logic signed [FIX_W-1:0]   integral_now;
    logic signed [ERR_W-1:0]   error_now;
    logic                      overflow;

    // model copy of the registers
    logic signed [GAIN_W-1:0] kp_reg;
    logic signed [GAIN_W-1:0] ki_reg;
    logic signed [GAIN_W-1:0] kd_reg;
    logic [LIM_W-1:0]         ilim_reg;
    logic signed [FIX_W-1:0]  dmin_reg;
    logic signed [FIX_W-1:0]  dmax_reg;

    // model copy of the loop state
    longint integ_acc;
    longint prev_err;
    bit     d_armed;

    steer_result_t pending_steer[$];
    plan_row_t     plan[$];

    int cycles_run   = 0;
    int fail_count   = 0;
    int ticks_sent   = 0;
    int unsafe_ticks = 0;
    int results_seen = 0;
    int ovf_seen     = 0;
    int settings     = 0;
    int bp_cycles    = 0;
    int tx_max       = 3;
    int rx_max       = 3;
    int hold_asks    = 0;
    int hold_seen    = 0;
    int rx_wait      = 0;

    gated_pid_steering_regulator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .safe         (safe),
        .setpoint     (setpoint),
        .actual       (actual),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive        (drive),
        .integral_now (integral_now),
        .error_now    (error_now),
        .overflow     (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles_run++;
        if (cycles_run >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles_run, pending_steer.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic flag(input string what);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("mismatch @%0d: %s", cycles_run, what);
    endtask

    // Q8.8 value times Q8.24 gain -> Q16.16, round half up
    function automatic longint scale_q(input longint v, input logic signed [GAIN_W-1:0] g);
        longint prod;
        prod = v * longint'(g);
        return (prod + 32768) >>> FRAC_SH;
    endfunction

    function automatic steer_result_t steer_law(input logic s,
                                                input logic signed [ANGLE_W-1:0] sp,
                                                input logic signed [ANGLE_W-1:0] act);
        steer_result_t r;
        longint err, p_term, acc, d_term, sum, lim;
        err      = longint'(sp) - longint'(act);
        r.drive  = '0;
        r.ovf    = 1'b0;
        if (s)
        begin
            lim    = longint'(ilim_reg);
            p_term = scale_q(err, kp_reg);
            acc    = integ_acc + scale_q(err, ki_reg);
            if (acc > lim)
                acc = lim;
            else if (acc < -lim)
                acc = -lim;
            integ_acc = acc;
            d_term    = d_armed ? scale_q(err - prev_err, kd_reg) : 0;
            prev_err  = err;
            d_armed   = 1'b1;
            sum       = p_term + acc + d_term;
            if (sum > S32_MAX || sum < S32_MIN)
            begin
                r.ovf     = 1'b1;
                sum       = 0;
                integ_acc = 0;
            end
            if (sum < longint'(dmin_reg))
                sum = longint'(dmin_reg);
            if (sum > longint'(dmax_reg))
                sum = longint'(dmax_reg);
            r.drive = sum[FIX_W-1:0];
        end
        else
        begin
            integ_acc = 0;
            prev_err  = 0;
            d_armed   = 1'b0;
        end
        r.integ = integ_acc[FIX_W-1:0];
        r.err   = err[ERR_W-1:0];
        return r;
    endfunction

    // out_ready pacing: random wait per beat, plus a long hold on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = 0;
        end
        else if (hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            rx_wait   = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                rx_wait = $urandom_range(0, rx_max);
            if (rx_wait > 0)
            begin
                out_ready <= 1'b0;
                rx_wait--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        steer_result_t want;
        if (rst_n && in_valid && !in_ready)
            bp_cycles++;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (overflow)
                ovf_seen++;
            if (pending_steer.size() == 0)
                flag("result beat with nothing pending");
            else
            begin
                want = pending_steer.pop_front();
                if (drive !== want.drive)
                    flag($sformatf("drive %0d, want %0d", drive, want.drive));
                if (integral_now !== want.integ)
                    flag($sformatf("integral %0d, want %0d", integral_now, want.integ));
                if (error_now !== want.err)
                    flag($sformatf("error %0d, want %0d", error_now, want.err));
                if (overflow !== want.ovf)
                    flag($sformatf("overflow %0b, want %0b", overflow, want.ovf));
            end
        end
    end

    task automatic put_reg(input cfg_index_t idx, input logic [FIX_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_GAIN_PROP:      kp_reg   = data;
            REG_GAIN_INT_DT:    ki_reg   = data;
            REG_GAIN_DERIV_DT:  kd_reg   = data;
            REG_INTEGRAL_LIMIT: ilim_reg = data[LIM_W-1:0];
            REG_DRIVE_MIN:      dmin_reg = data;
            REG_DRIVE_MAX:      dmax_reg = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic offer_tick(input logic s, input logic signed [ANGLE_W-1:0] sp,
                              input logic signed [ANGLE_W-1:0] act, input bit typed,
                              input steer_result_t want);
        int gap;
        steer_result_t pred;
        gap = $urandom_range(0, tx_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        safe     <= s;
        setpoint <= sp;
        actual   <= act;
        do
            @(posedge clk);
        while (!in_ready);
        pred = steer_law(s, sp, act);
        pending_steer.push_back(typed ? want : pred);
        ticks_sent++;
        if (!s)
            unsafe_ticks++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_steer.size() != 0)
            @(posedge clk);
    endtask

    function automatic plan_row_t tick_row(input logic s, input logic signed [ANGLE_W-1:0] sp,
                                           input logic signed [ANGLE_W-1:0] act);
        plan_row_t r;
        r.kind = ROW_TICK;
        r.safe = s;
        r.sp   = sp;
        r.act  = act;
        r.idx  = REG_GAIN_PROP;
        r.data = '0;
        r.want = '0;
        return r;
    endfunction

    // gated or trivially zero ticks: drive and integral are zero
    function automatic plan_row_t typed_row(input logic s, input logic signed [ANGLE_W-1:0] sp,
                                            input logic signed [ANGLE_W-1:0] act,
                                            input logic signed [ERR_W-1:0] err);
        plan_row_t r;
        r          = tick_row(s, sp, act);
        r.kind     = ROW_TICK_TYPED;
        r.want.err = err;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input cfg_index_t idx, input logic [FIX_W-1:0] data);
        plan_row_t r;
        r      = tick_row(1'b0, '0, '0);
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic logic [FIX_W-1:0] pick_gain();
        logic [FIX_W-1:0] g;
        case ($urandom_range(0, 7))
            0: g = 32'h7FFF_FFFF;
            1: g = 32'h8000_0000;
            2: g = '0;
            3: g = $urandom;
            default:
            begin
                g = $urandom_range(0, 32'h0400_0000);
                if ($urandom_range(0, 1) == 1)
                    g = -g;
            end
        endcase
        return g;
    endfunction

    task automatic random_setting(input bit wide_open);
        logic [FIX_W-1:0] lo, hi, lim;
        case ($urandom_range(0, 5))
            0: lim = '0;
            1: lim = 32'h7FFF_FFFF;
            2: lim = $urandom;      // bit 31 is dropped by the block
            default: lim = $urandom_range(0, 32'h0010_0000);
        endcase
        case ($urandom_range(0, 5))
            0:
            begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
            end
            1:
            begin
                // inverted window
                lo = $urandom_range(1, 32'h0010_0000);
                hi = -lo;
            end
            2:
            begin
                lo = $urandom;
                hi = $urandom;
            end
            default:
            begin
                hi = $urandom_range(0, 32'h0040_0000);
                lo = -$urandom_range(0, 32'h0040_0000);
            end
        endcase
        drain();
        if (wide_open)
        begin
            put_reg(REG_GAIN_PROP,      32'h7FFF_FFFF);
            put_reg(REG_GAIN_INT_DT,    32'h7FFF_FFFF);
            put_reg(REG_GAIN_DERIV_DT,  32'h8000_0000);
            put_reg(REG_INTEGRAL_LIMIT, 32'h7FFF_FFFF);
            put_reg(REG_DRIVE_MIN,      32'h8000_0000);
            put_reg(REG_DRIVE_MAX,      32'h7FFF_FFFF);
        end
        else
        begin
            put_reg(REG_GAIN_PROP,      pick_gain());
            put_reg(REG_GAIN_INT_DT,    pick_gain());
            put_reg(REG_GAIN_DERIV_DT,  pick_gain());
            put_reg(REG_INTEGRAL_LIMIT, lim);
            put_reg(REG_DRIVE_MIN,      lo);
            put_reg(REG_DRIVE_MAX,      hi);
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic random_tick();
        logic s;
        logic signed [ANGLE_W-1:0] sp, act;
        int pick;
        pick = $urandom_range(0, 99);
        s    = 1'b1;
        sp   = ANGLE_W'($urandom);
        act  = ANGLE_W'($urandom);
        if (pick < 50)
            act = sp + ANGLE_W'($urandom_range(0, 1024)) - 16'd512;   // tracking loop
        else if (pick < 60)
            act = sp;
        else if (pick < 72)
        begin
            sp  = ANGLE_W'($urandom_range(0, 8191)) - 16'd4096;
            act = ANGLE_W'($urandom_range(0, 8191)) - 16'd4096;
        end
        else if (pick < 82)
            s = 1'b0;
        else if (pick < 88)
        begin
            sp  = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            act = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        offer_tick(s, sp, act, 1'b0, '0);
    endtask

    initial
    begin : stimulus
        plan_row_t row;
        bit writing;
        kp_reg    = RST_GAIN_PROP;
        ki_reg    = RST_GAIN_INT_DT;
        kd_reg    = RST_GAIN_DERIV_DT;
        ilim_reg  = RST_INTEGRAL_LIMIT;
        dmin_reg  = RST_DRIVE_MIN;
        dmax_reg  = RST_DRIVE_MAX;
        integ_acc = 0;
        prev_err  = 0;
        d_armed   = 1'b0;
        writing   = 1'b0;

        // default registers
        plan.push_back(typed_row(1'b1, 16'sh0000, 16'sh0000, 17'sd0));
        plan.push_back(tick_row(1'b1, 16'sh7FFF, 16'sh8000));
        plan.push_back(tick_row(1'b1, 16'sh8000, 16'sh7FFF));
        plan.push_back(tick_row(1'b1, 16'sh7FFF, 16'sh7FFF));
        plan.push_back(typed_row(1'b0, 16'sh7FFF, 16'sh8000, 17'sd65535));
        plan.push_back(typed_row(1'b0, 16'sh8000, 16'sh7FFF, -17'sd65535));
        plan.push_back(tick_row(1'b1, 16'sh0100, 16'sh0000));   // derivative not yet armed
        plan.push_back(tick_row(1'b1, 16'sh0200, 16'sh0080));
        // unit derivative gain
        plan.push_back(reg_row(REG_GAIN_DERIV_DT, 32'h0100_0000));
        plan.push_back(tick_row(1'b1, 16'sh0100, 16'sh0000));
        plan.push_back(tick_row(1'b1, 16'sh0300, 16'sh0000));
        plan.push_back(tick_row(1'b1, -16'sh0100, 16'sh0000));
        // gains and clamp at positive extremes, widest bounds: sum overflows
        plan.push_back(reg_row(REG_GAIN_PROP,      32'h7FFF_FFFF));
        plan.push_back(reg_row(REG_GAIN_INT_DT,    32'h7FFF_FFFF));
        plan.push_back(reg_row(REG_GAIN_DERIV_DT,  32'h7FFF_FFFF));
        plan.push_back(reg_row(REG_INTEGRAL_LIMIT, 32'h7FFF_FFFF));
        plan.push_back(reg_row(REG_DRIVE_MIN,      32'h8000_0000));
        plan.push_back(reg_row(REG_DRIVE_MAX,      32'h7FFF_FFFF));
        plan.push_back(tick_row(1'b1, 16'sh7FFF, 16'sh8000));
        plan.push_back(tick_row(1'b1, 16'sh8000, 16'sh7FFF));
        plan.push_back(tick_row(1'b1, 16'sh0001, 16'sh0000));
        plan.push_back(tick_row(1'b1, 16'shFFFF, 16'sh0000));
        // negative extremes, zero clamp (bit 31 dropped), inverted bounds
        plan.push_back(reg_row(REG_GAIN_PROP,      32'h8000_0000));
        plan.push_back(reg_row(REG_GAIN_INT_DT,    32'h8000_0000));
        plan.push_back(reg_row(REG_GAIN_DERIV_DT,  32'h8000_0000));
        plan.push_back(reg_row(REG_INTEGRAL_LIMIT, 32'h8000_0000));
        plan.push_back(reg_row(REG_DRIVE_MIN,      32'h0001_0000));
        plan.push_back(reg_row(REG_DRIVE_MAX,      32'hFFFF_0000));
        plan.push_back(tick_row(1'b1, 16'sh1000, 16'sh0000));
        plan.push_back(tick_row(1'b1, -16'sh1000, 16'sh0000));
        plan.push_back(tick_row(1'b1, 16'sh0000, 16'sh7FFF));
        plan.push_back(typed_row(1'b0, 16'sh0000, 16'sh0000, 17'sd0));
        // unused indexes must not disturb anything
        plan.push_back(reg_row(REG_UNUSED_LO, 32'hFFFF_FFFF));
        plan.push_back(reg_row(REG_UNUSED_HI, 32'h0000_0000));
        plan.push_back(tick_row(1'b1, 16'sh0400, 16'sh0100));
        plan.push_back(tick_row(1'b1, 16'sh0400, 16'sh0200));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_WRITE)
            begin
                if (!writing)
                begin
                    drain();
                    settings++;
                end
                writing = 1'b1;
                put_reg(row.idx, row.data);
            end
            else
            begin
                if (writing)
                    cfg_we <= 1'b0;
                writing = 1'b0;
                offer_tick(row.safe, row.sp, row.act, row.kind == ROW_TICK_TYPED, row.want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                drain();
                put_reg(REG_GAIN_PROP,      RST_GAIN_PROP);
                put_reg(REG_GAIN_INT_DT,    RST_GAIN_INT_DT);
                put_reg(REG_GAIN_DERIV_DT,  RST_GAIN_DERIV_DT);
                put_reg(REG_INTEGRAL_LIMIT, FIX_W'(RST_INTEGRAL_LIMIT));
                put_reg(REG_DRIVE_MIN,      RST_DRIVE_MIN);
                put_reg(REG_DRIVE_MAX,      RST_DRIVE_MAX);
                cfg_we <= 1'b0;
                settings++;
            end
            else
                random_setting(ph == NUM_PHASES - 1);

            // pacing per phase, with full-rate stretches on both sides
            case (ph % 4)
                0: begin tx_max = 0; rx_max = 0; end
                1: begin tx_max = 9; rx_max = 9; end
                2: begin tx_max = 0; rx_max = 9; end
                default: begin tx_max = 9; rx_max = 0; end
            endcase

            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                if (ph == 2 && n == 10)
                    hold_asks++;        // sink stalls, source keeps pushing
                if (ph == 5 && n == 45)
                    drain();            // source waits for an empty pipe
                random_tick();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("ran %0d ticks (%0d gated off) over %0d register settings",
                 ticks_sent, unsafe_ticks, settings);
        $display("checked %0d results, %0d with overflow; %0d cycles of input backpressure",
                 results_seen, ovf_seen, bp_cycles);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
